// ===== sv/acd_pkg.sv =====
package acd_pkg;

    // Flags are stored 64 to a word; the summary RAM uses the same word width.
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    localparam int COLOR_W = 10;
    // Wide enough for any color or word index up to the largest color count.
    localparam int IDX_W   = 17;

    localparam logic OP_INIT = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [COLOR_W-1:0] color;
        logic               advice_bit;
    } in_item_t;

    typedef struct packed {
        logic               evicted;
        logic [COLOR_W-1:0] evicted_color;
        logic               error;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_K,
        ST_CHK,
        ST_FS,
        ST_FL,
        ST_RD_I,
        ST_WR_I,
        ST_PUSH
    } state_t;

endpackage

// ===== sv/advice_driven_cache_eviction.sv =====
// Advice-driven cache eviction tracker.
// Input channel (in_valid / in_ready / in_data) carries init and request
// transactions; the output channel (out_valid / out_ready / out_data) carries
// one result per request and none per init transaction.
// Keep and evictable flags live in two RAMs of 64-bit words. A summary RAM
// holds one bit per nonzero evictable word, and a top register holds one bit
// per nonzero summary word. One shared find-first unit walks top, summary and
// leaf in turn to locate the lowest evictable color.
// A request reads its keep word, checks for a hit and, on a miss with a
// nonempty evictable set, searches summary and leaf; then, like an init, it
// reads and writes the flag words for its advice, and its result is loaded
// into the output register from the push state. Every flag update is a
// registered RAM read followed by a write, and the eviction search is two
// dependent RAM reads, summary then leaf, after the top register. After reset
// the block sweeps the RAMs clear, one word per cycle, with in_ready low.
// A result waits in the output register while out_ready is low; the next
// transaction is still accepted and processed, and only a second result
// holds the block until the first one is taken.
module advice_driven_cache_eviction #(
    parameter int COLOR_COUNT = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  acd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output acd_pkg::out_item_t out_data
);

    localparam int W   = acd_pkg::WORD_W;
    localparam int BW  = acd_pkg::BIT_W;
    localparam int IW  = acd_pkg::IDX_W;
    localparam int NW  = (COLOR_COUNT + W - 1) / W;
    localparam int NS  = (NW + W - 1) / W;
    localparam int WAW = NW > 1 ? $clog2(NW) : 1;
    localparam int SAW = NS > 1 ? $clog2(NS) : 1;
    localparam logic [IW-1:0] COUNT_L = IW'(COLOR_COUNT);

    acd_pkg::state_t    state_reg, state_next;
    acd_pkg::in_item_t  item_reg;
    acd_pkg::out_item_t res_reg, res_next;
    acd_pkg::out_item_t out_data_reg;
    logic               out_valid_reg;
    logic [WAW-1:0]     clr_reg, clr_next;
    logic [NS-1:0]      top_reg, top_next;
    logic [SAW-1:0]     s_reg;
    logic [WAW-1:0]     w_reg;
    logic [BW-1:0]      wlo_reg;
    logic [W-1:0]       sword_reg;

    logic [IW-1:0]  color_ext;
    logic           in_range;
    logic [WAW-1:0] cw;
    logic [SAW-1:0] cs;
    logic [BW-1:0]  cbit;
    logic [BW-1:0]  cw_lo;
    logic [W-1:0]   cmask;
    logic [W-1:0]   wmask;
    logic           hit;
    logic           push_load;

    logic           k_we, e_we, s_we;
    logic [WAW-1:0] k_waddr, k_raddr, e_waddr, e_raddr;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [W-1:0]   k_wdata, k_rdata, e_wdata, e_rdata, s_wdata, s_rdata;
    logic [W-1:0]   leaf_left, sum_left;

    logic [W-1:0]   ffs_vec;
    logic           ffs_found;
    logic [BW-1:0]  ffs_idx;

    acd_ram #(.WIDTH(W), .DEPTH(NW)) u_keep_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    acd_ram #(.WIDTH(W), .DEPTH(NW)) u_evict_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    acd_ram #(.WIDTH(W), .DEPTH(NS)) u_sum_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    acd_ffs u_ffs (
        .vec   (ffs_vec),
        .found (ffs_found),
        .idx   (ffs_idx)
    );

    assign color_ext = IW'(item_reg.color);
    assign in_range  = color_ext < COUNT_L;
    assign cw        = WAW'(color_ext >> BW);
    assign cs        = SAW'(color_ext >> (2 * BW));
    assign cbit      = item_reg.color[BW-1:0];
    assign cw_lo     = BW'(color_ext >> BW);
    assign cmask     = W'(1) << cbit;
    assign wmask     = W'(1) << cw_lo;
    assign hit       = in_range && k_rdata[cbit];
    assign leaf_left = e_rdata & ~(W'(1) << ffs_idx);
    assign sum_left  = sword_reg & ~(W'(1) << wlo_reg);

    assign in_ready  = (state_reg == acd_pkg::ST_IDLE);
    assign push_load = (state_reg == acd_pkg::ST_PUSH) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acd_pkg::ST_CLEAR:
            begin
                if (clr_reg == WAW'(NW - 1))
                begin
                    state_next = acd_pkg::ST_IDLE;
                end
            end
            acd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_data.opcode == acd_pkg::OP_REQ) ?
                                 acd_pkg::ST_RD_K : acd_pkg::ST_RD_I;
                end
            end
            acd_pkg::ST_RD_K: state_next = acd_pkg::ST_CHK;
            acd_pkg::ST_CHK:
            begin
                if (hit || top_reg == '0)
                begin
                    state_next = acd_pkg::ST_RD_I;
                end
                else
                begin
                    state_next = acd_pkg::ST_FS;
                end
            end
            acd_pkg::ST_FS:   state_next = acd_pkg::ST_FL;
            acd_pkg::ST_FL:   state_next = acd_pkg::ST_RD_I;
            acd_pkg::ST_RD_I: state_next = acd_pkg::ST_WR_I;
            acd_pkg::ST_WR_I:
            begin
                state_next = (item_reg.opcode == acd_pkg::OP_REQ) ?
                             acd_pkg::ST_PUSH : acd_pkg::ST_IDLE;
            end
            acd_pkg::ST_PUSH:
            begin
                if (push_load)
                begin
                    state_next = acd_pkg::ST_IDLE;
                end
            end
            default: state_next = acd_pkg::ST_CLEAR;
        endcase
    end

    // RAM ports, find-first input and bookkeeping for each state.
    always_comb
    begin
        k_we     = 1'b0;
        k_waddr  = cw;
        k_wdata  = k_rdata | cmask;
        k_raddr  = cw;
        e_we     = 1'b0;
        e_waddr  = cw;
        e_wdata  = e_rdata | cmask;
        e_raddr  = cw;
        s_we     = 1'b0;
        s_waddr  = cs;
        s_wdata  = s_rdata | wmask;
        s_raddr  = cs;
        ffs_vec  = W'(top_reg);
        top_next = top_reg;
        clr_next = clr_reg;
        res_next = res_reg;
        case (state_reg)
            acd_pkg::ST_CLEAR:
            begin
                k_we     = 1'b1;
                k_waddr  = clr_reg;
                k_wdata  = '0;
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                e_wdata  = '0;
                s_we     = IW'(clr_reg) < IW'(NS);
                s_waddr  = SAW'(clr_reg);
                s_wdata  = '0;
                clr_next = clr_reg + WAW'(1);
            end
            acd_pkg::ST_CHK:
            begin
                ffs_vec  = W'(top_reg);
                s_raddr  = SAW'(ffs_idx);
                res_next = '0;
                if (hit)
                begin
                    k_we    = 1'b1;
                    k_wdata = k_rdata & ~cmask;
                end
                else if (top_reg == '0)
                begin
                    res_next.error = 1'b1;
                end
            end
            acd_pkg::ST_FS:
            begin
                ffs_vec = s_rdata;
                e_raddr = WAW'((IW'(s_reg) << BW) | IW'(ffs_idx));
            end
            acd_pkg::ST_FL:
            begin
                ffs_vec = e_rdata;
                e_we    = 1'b1;
                e_waddr = w_reg;
                e_wdata = leaf_left;
                // An emptied leaf word drops out of the summary, and so on upward.
                if (leaf_left == '0)
                begin
                    s_we    = 1'b1;
                    s_waddr = s_reg;
                    s_wdata = sum_left;
                    if (sum_left == '0)
                    begin
                        top_next[s_reg] = 1'b0;
                    end
                end
                res_next.evicted       = 1'b1;
                res_next.evicted_color =
                    acd_pkg::COLOR_W'((IW'(w_reg) << BW) | IW'(ffs_idx));
                res_next.error         = 1'b0;
            end
            acd_pkg::ST_WR_I:
            begin
                if (in_range)
                begin
                    if (item_reg.advice_bit)
                    begin
                        k_we = 1'b1;
                    end
                    else
                    begin
                        e_we         = 1'b1;
                        s_we         = 1'b1;
                        top_next[cs] = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acd_pkg::ST_CLEAR;
            clr_reg       <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            top_reg   <= top_next;
            if (push_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (state_reg == acd_pkg::ST_CHK)
        begin
            s_reg <= SAW'(ffs_idx);
        end
        if (state_reg == acd_pkg::ST_FS)
        begin
            w_reg     <= WAW'((IW'(s_reg) << BW) | IW'(ffs_idx));
            wlo_reg   <= ffs_idx;
            sword_reg <= s_rdata;
        end
        res_reg <= res_next;
        if (push_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    // The summary bits promise a nonzero word at each level of the search.
    a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acd_pkg::ST_FS |-> ffs_found)
        else $error("summary word empty although its top bit is set");

    a_leaf_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == acd_pkg::ST_FL |-> ffs_found)
        else $error("leaf word empty although its summary bit is set");

    a_evict_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.evicted && out_data.error))
        else $error("result reports both an eviction and an error");

    a_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.evicted |-> out_data.evicted_color == '0)
        else $error("evicted color nonzero without an eviction");

endmodule

// ===== sv/acd_ram.sv =====
module acd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/acd_ffs.sv =====
module acd_ffs (
    input  logic [acd_pkg::WORD_W-1:0] vec,
    output logic                       found,
    output logic [acd_pkg::BIT_W-1:0]  idx
);

    // Priority encoder: lowest set bit wins.
    always_comb
    begin
        idx = '0;
        for (int i = acd_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = acd_pkg::BIT_W'(i);
            end
        end
    end

    assign found = |vec;

endmodule

// ===== tb/tb_advice_driven_cache_eviction.sv =====
`timescale 1ns / 1ps

module tb_advice_driven_cache_eviction;

    localparam int COLORS = 1024;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    acd_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    acd_pkg::out_item_t out_data;

    advice_driven_cache_eviction #(
        .COLOR_COUNT(COLORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Shadow copy of the two flag sets.
    bit                 keep_set  [COLORS];
    bit                 evict_set [COLORS];
    acd_pkg::out_item_t pending_results[$];
    int                 mismatches = 0;
    int                 burst_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[advice_driven_cache_eviction] ERROR");
        $finish;
    end

    function automatic acd_pkg::in_item_t make_item(input logic op, input int color,
                                                    input logic adv);
        acd_pkg::in_item_t it;
        it.opcode     = op;
        it.color      = color[acd_pkg::COLOR_W-1:0];
        it.advice_bit = adv;
        return it;
    endfunction

    // Updates the shadow sets for one accepted transaction and queues the
    // expected result of a request.
    function automatic void track_transaction(input acd_pkg::in_item_t it);
        acd_pkg::out_item_t res;
        int                 c;
        int                 victim;
        c = int'(it.color);
        if (it.opcode == acd_pkg::OP_REQ)
        begin
            res = '0;
            if (keep_set[c])
            begin
                keep_set[c] = 1'b0;
            end
            else
            begin
                victim = -1;
                for (int i = 0; i < COLORS; i++)
                begin
                    if (evict_set[i] && victim < 0)
                        victim = i;
                end
                if (victim >= 0)
                begin
                    evict_set[victim] = 1'b0;
                    res.evicted       = 1'b1;
                    res.evicted_color = victim[acd_pkg::COLOR_W-1:0];
                end
                else
                begin
                    res.error = 1'b1;
                end
            end
            pending_results = {pending_results, res};
        end
        if (it.advice_bit)
            keep_set[c] = 1'b1;
        else
            evict_set[c] = 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back transaction never toggles it.
    task automatic issue_transaction(input acd_pkg::in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(8, 30);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(30, 80);
            else
                burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        track_transaction(it);
        @(negedge clk);
    endtask

    task automatic send(input logic op, input int color, input logic adv);
        issue_transaction(make_item(op, color, adv));
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: evicted=%0d evicted_color=%0d error=%0d",
                       out_data.evicted, out_data.evicted_color, out_data.error);
                mismatches++;
            end
            else
            begin
                if (out_data.evicted !== pending_results[0].evicted)
                begin
                    $error("evicted: expected %0d, got %0d",
                           pending_results[0].evicted, out_data.evicted);
                    mismatches++;
                end
                if (out_data.evicted_color !== pending_results[0].evicted_color)
                begin
                    $error("evicted_color: expected %0d, got %0d",
                           pending_results[0].evicted_color, out_data.evicted_color);
                    mismatches++;
                end
                if (out_data.error !== pending_results[0].error)
                begin
                    $error("error: expected %0d, got %0d",
                           pending_results[0].error, out_data.error);
                    mismatches++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver: switches at random between four out_ready patterns, from always ready to mostly stalled.
    initial
    begin
        int mode;
        int span;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= ($urandom_range(0, 7) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // A miss on an empty evictable set, then the same color coming back as
    // evictable and as kept.
    task automatic test_empty_set_miss();
        send(acd_pkg::OP_REQ, 5, 1'b0);
        send(acd_pkg::OP_REQ, 5, 1'b1);
        send(acd_pkg::OP_REQ, 5, 1'b0);
        send(acd_pkg::OP_REQ, 1023, 1'b1);
    endtask

    task automatic test_keep_hits();
        send(acd_pkg::OP_INIT, 0, 1'b1);
        send(acd_pkg::OP_INIT, 1023, 1'b0);
        send(acd_pkg::OP_REQ, 1023, 1'b0);
        send(acd_pkg::OP_REQ, 0, 1'b1);
        send(acd_pkg::OP_REQ, 0, 1'b0);
    endtask

    // Lowest evictable color across word boundaries.
    task automatic test_lowest_victim();
        send(acd_pkg::OP_INIT, 512, 1'b0);
        send(acd_pkg::OP_INIT, 64, 1'b0);
        send(acd_pkg::OP_INIT, 63, 1'b0);
        send(acd_pkg::OP_REQ, 700, 1'b0);
        send(acd_pkg::OP_REQ, 700, 1'b1);
        send(acd_pkg::OP_REQ, 63, 1'b0);
        send(acd_pkg::OP_REQ, 682, 1'b1);
        send(acd_pkg::OP_REQ, 341, 1'b0);
    endtask

    // Init only sets flags, so one color can sit in both sets at once.
    task automatic test_both_sets();
        send(acd_pkg::OP_INIT, 300, 1'b1);
        send(acd_pkg::OP_INIT, 300, 1'b0);
        send(acd_pkg::OP_REQ, 300, 1'b1);
        send(acd_pkg::OP_REQ, 300, 1'b0);
        send(acd_pkg::OP_REQ, 300, 1'b0);
        send(acd_pkg::OP_INIT, 1023, 1'b1);
    endtask

    // Mostly requests on a small pool of colors so hits and evictions mix.
    task automatic test_working_set(input int count, input int pool_size);
        int pool[$];
        int c;
        pool = {pool, 0};
        pool = {pool, COLORS - 1};
        while (pool.size() < pool_size)
            pool = {pool, int'($urandom_range(0, COLORS - 1))};
        repeat (count)
        begin
            if ($urandom_range(0, 15) == 0)
                c = $urandom_range(0, COLORS - 1);
            else
                c = pool[$urandom_range(0, pool.size() - 1)];
            send(($urandom_range(0, 3) == 0) ? acd_pkg::OP_INIT : acd_pkg::OP_REQ, c,
                 $urandom_range(0, 1) == 1);
        end
    endtask

    // Full color range with extra evictable inits, so the set spreads over
    // many words.
    task automatic test_wide_range(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 2) == 0)
                send(acd_pkg::OP_INIT, $urandom_range(0, COLORS - 1),
                     $urandom_range(0, 3) == 0);
            else
                send(acd_pkg::OP_REQ, $urandom_range(0, COLORS - 1),
                     $urandom_range(0, 1) == 1);
        end
    endtask

    // Kept-advice misses drain the evictable set until requests hit empty.
    task automatic test_drain(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 19) == 0)
                send(acd_pkg::OP_INIT, $urandom_range(0, COLORS - 1), 1'b0);
            else
                send(acd_pkg::OP_REQ, $urandom_range(0, COLORS - 1),
                     $urandom_range(0, 9) == 0);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_set_miss();
        test_keep_hits();
        test_lowest_victim();
        test_both_sets();

        test_working_set(400, 24);
        test_wide_range(450);
        test_drain(300);
        test_working_set(300, 8);
        test_wide_range(200);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);

        if (mismatches == 0)
            $display("[advice_driven_cache_eviction] OK");
        else
            $display("[advice_driven_cache_eviction] ERROR");
        $finish;
    end

endmodule
